// ----- hw/rtl/assert_macros.svh -----
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/rtss_pkg.sv -----
`default_nettype none
package rtss_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int TOTAL_W = 7;

	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] ip_addr;
		logic [47:0] next_hop_mac;
		logic [7:0]  iface_index;
		logic [7:0]  hop_count;
		logic [31:0] timestamp;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [47:0]        out_next_hop;
		logic [7:0]         out_iface;
		logic [7:0]         out_hops;
		logic [31:0]        out_stamp;
		logic [TOTAL_W-1:0] entry_total;
	} rsp_t;

	typedef struct packed {
		logic [31:0] key;
		logic [47:0] mac;
		logic [7:0]  iface;
		logic [7:0]  hops;
		logic [31:0] stamp;
	} entry_t;

	typedef struct packed {
		logic start;
		logic take;
	} eng_ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} eng_sts_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MOVE_RD,
		S_MOVE_WR,
		S_DONE
	} eng_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rtss_engine.sv -----
`default_nettype none
`include "assert_macros.svh"
module rtss_engine (
	input  wire               clk,
	input  wire               arst_n,
	input  rtss_pkg::eng_ctl_t ctl,
	input  rtss_pkg::req_t     cmd,
	output rtss_pkg::eng_sts_t sts,
	output rtss_pkg::rsp_t     result
);

	localparam int IDX_W = rtss_pkg::IDX_W;
	localparam int CNT_W = rtss_pkg::CNT_W;

	rtss_pkg::entry_t     mem [rtss_pkg::ENTRIES];
	rtss_pkg::entry_t     rd_data_q;
	rtss_pkg::entry_t     wr_data;
	logic [IDX_W-1:0]     rd_addr;
	logic [IDX_W-1:0]     wr_addr;
	logic                 wr_en;

	rtss_pkg::eng_state_t st_q, st_d;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     scan_q;
	logic                 pend_s1;
	logic [IDX_W-1:0]     pend_idx_s1;
	logic [IDX_W-1:0]     hit_idx_q;
	logic [31:0]          key_q;
	logic [1:0]           op_q;
	rtss_pkg::rsp_t       res_q;

	logic                 full;
	logic                 empty;
	logic                 is_insert;
	logic                 key_hit;
	logic                 scan_miss;
	logic                 issue_ok;
	logic [IDX_W-1:0]     last_idx;

	assign full      = (count_q == CNT_W'(rtss_pkg::ENTRIES));
	assign empty     = (count_q == '0);
	assign is_insert = (cmd.action == rtss_pkg::ACT_INSERT);
	assign key_hit   = pend_s1 && (rd_data_q.key == key_q);
	assign scan_miss = pend_s1 && !key_hit
		&& (CNT_W'(pend_idx_s1) == count_q - CNT_W'(1));
	assign issue_ok  = (scan_q < count_q);
	assign last_idx  = IDX_W'(count_q - CNT_W'(1));

	always_comb begin
		st_d          = st_q;
		sts.idle      = (st_q == rtss_pkg::S_IDLE);
		sts.done      = (st_q == rtss_pkg::S_DONE);
		rd_addr       = '0;
		wr_en         = 1'b0;
		wr_addr       = count_q[IDX_W-1:0];
		wr_data.key   = cmd.ip_addr;
		wr_data.mac   = cmd.next_hop_mac;
		wr_data.iface = cmd.iface_index;
		wr_data.hops  = cmd.hop_count;
		wr_data.stamp = cmd.timestamp;
		case (st_q)
			rtss_pkg::S_IDLE: begin
				// entry 0 is read here so the scan sees it next cycle
				if (ctl.start) begin
					if (is_insert) begin
						st_d  = rtss_pkg::S_DONE;
						wr_en = !full;
					end else if (empty) begin
						st_d = rtss_pkg::S_DONE;
					end else begin
						st_d = rtss_pkg::S_SCAN;
					end
				end
			end
			rtss_pkg::S_SCAN: begin
				rd_addr = scan_q[IDX_W-1:0];
				if (key_hit) begin
					st_d = (op_q == rtss_pkg::ACT_REMOVE) ? rtss_pkg::S_MOVE_RD
						: rtss_pkg::S_DONE;
				end else if (scan_miss) begin
					st_d = rtss_pkg::S_DONE;
				end
			end
			rtss_pkg::S_MOVE_RD: begin
				rd_addr = last_idx;
				st_d    = rtss_pkg::S_MOVE_WR;
			end
			rtss_pkg::S_MOVE_WR: begin
				// last entry fills the hole
				wr_en   = 1'b1;
				wr_addr = hit_idx_q;
				wr_data = rd_data_q;
				st_d    = rtss_pkg::S_DONE;
			end
			rtss_pkg::S_DONE: begin
				if (ctl.take) begin
					st_d = rtss_pkg::S_IDLE;
				end
			end
			default: begin
				st_d = rtss_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= rtss_pkg::S_IDLE;
			count_q <= '0;
			scan_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			st_q    <= st_d;
			pend_s1 <= (st_q == rtss_pkg::S_IDLE && ctl.start && !is_insert && !empty)
				|| (st_q == rtss_pkg::S_SCAN && !key_hit && !scan_miss && issue_ok);
			if (st_q == rtss_pkg::S_IDLE && ctl.start) begin
				if (is_insert) begin
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end else if (!empty) begin
					scan_q  <= CNT_W'(1);
				end
			end
			if (st_q == rtss_pkg::S_SCAN && !key_hit && !scan_miss && issue_ok) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (st_q == rtss_pkg::S_MOVE_WR) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == rtss_pkg::S_IDLE && ctl.start) begin
			op_q        <= cmd.action;
			key_q       <= cmd.ip_addr;
			pend_idx_s1 <= '0;
			res_q       <= '{status: is_insert
				? (full ? rtss_pkg::ST_FULL : rtss_pkg::ST_OK)
				: (empty ? rtss_pkg::ST_MISS : rtss_pkg::ST_OK), default: '0};
		end
		if (st_q == rtss_pkg::S_SCAN) begin
			pend_idx_s1 <= scan_q[IDX_W-1:0];
			if (key_hit) begin
				hit_idx_q <= pend_idx_s1;
				if (op_q != rtss_pkg::ACT_REMOVE) begin
					res_q.out_next_hop <= rd_data_q.mac;
					res_q.out_iface    <= rd_data_q.iface;
					res_q.out_hops     <= rd_data_q.hops;
					res_q.out_stamp    <= rd_data_q.stamp;
				end
			end else if (scan_miss) begin
				res_q.status <= rtss_pkg::ST_MISS;
			end
		end
	end

	always_comb begin
		result             = res_q;
		result.entry_total = rtss_pkg::TOTAL_W'(count_q);
	end

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(rtss_pkg::ENTRIES), "count over capacity")
	`ASSERT_NEXT(a_count_hold, clk, arst_n, st_q != rtss_pkg::S_IDLE && st_q != rtss_pkg::S_MOVE_WR, $stable(count_q), "count moved mid-operation")
	`ASSERT_ALWAYS(a_pend_range, clk, arst_n, !pend_s1 || (st_q == rtss_pkg::S_SCAN && CNT_W'(pend_idx_s1) < count_q), "compare outside valid entries")
	`ASSERT_NEXT(a_done_hold, clk, arst_n, sts.done && !ctl.take, sts.done && $stable(res_q), "result lost before taken")

endmodule
`default_nettype wire

// ----- hw/rtl/route_table_search_swap_remove.sv -----
`default_nettype none
// Unsorted route table of rtss_pkg::ENTRIES entries keyed by a 32-bit address, one request
// word in, one response word out. Insert appends the entry as the word is accepted and
// reports a full table instead of writing. Lookup and remove scan from entry 0 one entry
// per cycle through the single read port of the entry RAM; remove then copies the last
// entry into the hole. The slowest word is a remove that hits the last entry. The block
// takes one word at a time; the next word is accepted once the previous response sits in
// the output register. Entries are never cleared; only those below the count are compared.
module route_table_search_swap_remove (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_ready,
	input  rtss_pkg::req_t req,
	output logic           rsp_valid,
	input  wire            rsp_ready,
	output rtss_pkg::rsp_t rsp
);

	rtss_pkg::eng_ctl_t ctl;
	rtss_pkg::eng_sts_t sts;
	rtss_pkg::rsp_t     result;
	logic               rsp_valid_q;
	rtss_pkg::rsp_t     rsp_q;

	assign req_ready = sts.idle;
	assign ctl.start = req_valid && sts.idle;
	assign ctl.take  = sts.done && (!rsp_valid_q || rsp_ready);

	rtss_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (req),
		.sts    (sts),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire
